// ===== hdl/hrp_pkg.sv =====
// Package for the HTTP request header parser: sizes, character and code
// constants, parse phase encoding and the result record.
// No dependencies; the top level imports it.
package hrp_pkg;

	localparam int MAX_HEADER_BYTES = 4096;
	localparam int MIN_HEADER_BYTES = 3;
	localparam int BC_W  = $clog2(MAX_HEADER_BYTES + 1);
	localparam int LEN_W = 13;
	localparam int CAP_W = 13;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam logic [2:0] FLD_STATUS  = 3'd0;
	localparam logic [2:0] FLD_METHOD  = 3'd1;
	localparam logic [2:0] FLD_TARGET  = 3'd2;
	localparam logic [2:0] FLD_VERSION = 3'd3;
	localparam logic [2:0] FLD_HOST    = 3'd4;

	localparam logic [2:0] ST_OK             = 3'd0;
	localparam logic [2:0] ST_TOO_SHORT      = 3'd1;
	localparam logic [2:0] ST_NO_METHOD_SP   = 3'd2;
	localparam logic [2:0] ST_NO_TARGET_SP   = 3'd3;
	localparam logic [2:0] ST_NO_VERSION_EOL = 3'd4;
	localparam logic [2:0] ST_NO_HOST        = 3'd5;
	localparam logic [2:0] ST_NO_COLON       = 3'd6;
	localparam logic [2:0] ST_HOST_TOO_LONG  = 3'd7;

	localparam logic [2:0] HOST_WORD_LEN = 3'd4;

	typedef enum logic [7:0] {
		PH_METHOD  = 8'b0000_0001,
		PH_TARGET  = 8'b0000_0010,
		PH_VERSION = 8'b0000_0100,
		PH_SEARCH  = 8'b0000_1000,
		PH_COLON   = 8'b0001_0000,
		PH_SPACE   = 8'b0010_0000,
		PH_VALUE   = 8'b0100_0000,
		PH_DRAIN   = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [2:0] fld;
		logic [7:0] dat;
		logic       done;
		logic [2:0] status;
	} result_t;

	// Characters of "Host" by position
	function automatic logic [7:0] host_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = 8'h48;
			2'd1: c = 8'h6F;
			2'd2: c = 8'h73;
			2'd3: c = 8'h74;
			default: c = 8'h48;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/hrp_if.sv =====
// Valid/ready channel interfaces for header bytes in and parsed results out.
// Depends on nothing but plain logic types.
interface hrp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface hrp_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] out_field;
	logic [7:0] out_byte;
	logic       out_done;
	logic [2:0] out_status;

	modport source (output valid, output out_field, output out_byte, output out_done,
		output out_status, input ready);
	modport sink   (input valid, input out_field, input out_byte, input out_done,
		input out_status, output ready);
endinterface

// ===== hdl/http_request_header_parser_top.sv =====
// HTTP request header parser top level: input register, one-pass parse logic
// and a four-entry result queue. Depends on hrp_pkg and hrp_if.sv.
//
// Usage:
//   hdr carries one header byte per transaction; in_last marks the final byte
//   of a request. fld carries results: method, target, version and host value
//   bytes tagged by out_field, and one result with out_done set per request,
//   carrying out_status (folded onto the last field byte when one is emitted
//   by the same byte, else a status-only result with out_field zero).
//   host_capacity is written by cfg_we/cfg_wdata, by the user only while the
//   block is idle; the block itself does not enforce this.
// Path: a registered byte is parsed and its results written to the queue,
//   whose head drives fld directly.
// Throughput: one byte per cycle while the queue has room. A byte yields
//   zero, one or two results, and the queue drains one per cycle with fld.ready.
// Stall: the input register advances only when the queue has room for two
//   results; otherwise hdr.ready drops and the byte is held.
// Reset: arst_n clears the parse state, empties the queue and sets
//   host_capacity to 256. State is also cleared after every in_last byte.
module http_request_header_parser_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [hrp_pkg::CAP_W-1:0] cfg_wdata,
	hrp_in_if.sink                    hdr,
	hrp_out_if.source                 fld
);
	import hrp_pkg::*;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Parse state
	phase_t           phase_q;
	logic [2:0]       mc_q;
	logic [BC_W-1:0]  bc_q;
	logic [LEN_W-1:0] hl_q;
	logic             cr_q;
	logic [CAP_W-1:0] cap_q;

	// Result queue
	result_t          fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	logic adv, pop, room;

	// Next-state and emission logic
	phase_t           ph_d;
	logic [2:0]       mc_d;
	logic [BC_W-1:0]  bc_d;
	logic             cr_d;
	logic             take;
	logic             a_v, b_v, c_v;
	logic [2:0]       a_f, b_f;
	logic             fin;
	logic [2:0]       fst_raw;
	logic             fst_host;
	logic [1:0]       hcnt;
	logic [LEN_W:0]   hl_sum;
	logic [LEN_W-1:0] hl_fin;
	logic [2:0]       fst;
	result_t          ra, rb, rc, r_lo, r_hi;
	logic [1:0]       nout;

	assign pop  = fld.valid && fld.ready;
	assign room = (cnt_q <= CNT_W'(FIFO_DEPTH - 2)) ||
		((cnt_q == CNT_W'(FIFO_DEPTH - 1)) && pop);
	assign adv  = valid_s1 && room;
	assign hdr.ready = !valid_s1 || room;

	always_comb begin
		ph_d     = phase_q;
		mc_d     = mc_q;
		bc_d     = bc_q;
		cr_d     = cr_q;
		a_v      = 1'b0;
		a_f      = FLD_VERSION;
		b_v      = 1'b0;
		b_f      = FLD_METHOD;
		c_v      = 1'b0;
		fin      = 1'b0;
		fst_raw  = ST_OK;
		fst_host = 1'b0;
		take     = bc_q < BC_W'(MAX_HEADER_BYTES);

		if (take) begin
			bc_d = bc_q + BC_W'(1);
			unique case (phase_q)
				PH_METHOD: begin
					if (byte_s1 == CH_SP) ph_d = PH_TARGET;
					else begin
						b_v = 1'b1;
						b_f = FLD_METHOD;
					end
				end
				PH_TARGET: begin
					if (byte_s1 == CH_SP) ph_d = PH_VERSION;
					else begin
						b_v = 1'b1;
						b_f = FLD_TARGET;
					end
				end
				PH_VERSION: begin
					if (cr_q && byte_s1 == CH_LF) begin
						cr_d = 1'b0;
						ph_d = PH_SEARCH;
						mc_d = '0;
					end else begin
						// release a held CR that was not part of a line end
						a_v  = cr_q;
						a_f  = FLD_VERSION;
						cr_d = byte_s1 == CH_CR;
						b_v  = byte_s1 != CH_CR;
						b_f  = FLD_VERSION;
					end
				end
				PH_SEARCH: begin
					if (mc_q < HOST_WORD_LEN && byte_s1 == host_char(mc_q[1:0]))
						mc_d = mc_q + 3'd1;
					else
						mc_d = (byte_s1 == host_char(2'd0)) ? 3'd1 : 3'd0;
					if (mc_d >= HOST_WORD_LEN) begin
						ph_d = PH_COLON;
						cr_d = 1'b0;
					end
				end
				PH_COLON: begin
					if (cr_q && byte_s1 == CH_LF) begin
						fin     = 1'b1;
						fst_raw = ST_NO_COLON;
						ph_d    = PH_DRAIN;
					end else begin
						cr_d = byte_s1 == CH_CR;
						if (byte_s1 == CH_COLON) ph_d = PH_SPACE;
					end
				end
				PH_SPACE, PH_VALUE: begin
					ph_d = PH_VALUE;
					// drop the one optional space after the colon
					if (!(phase_q == PH_SPACE && byte_s1 == CH_SP)) begin
						if (cr_q && byte_s1 == CH_LF) begin
							cr_d     = 1'b0;
							fin      = 1'b1;
							fst_host = 1'b1;
							ph_d     = PH_DRAIN;
						end else begin
							a_v  = cr_q;
							a_f  = FLD_HOST;
							cr_d = byte_s1 == CH_CR;
							b_v  = byte_s1 != CH_CR;
							b_f  = FLD_HOST;
						end
					end
				end
				default: ;
			endcase
		end

		if (last_s1 && ph_d != PH_DRAIN) begin
			fin = 1'b1;
			if (bc_d < BC_W'(MIN_HEADER_BYTES)) fst_raw = ST_TOO_SHORT;
			else begin
				unique case (ph_d)
					PH_METHOD:  fst_raw = ST_NO_METHOD_SP;
					PH_TARGET:  fst_raw = ST_NO_TARGET_SP;
					PH_VERSION: fst_raw = ST_NO_VERSION_EOL;
					PH_SEARCH:  fst_raw = ST_NO_HOST;
					PH_COLON:   fst_raw = ST_NO_COLON;
					default: begin
						c_v      = cr_d;
						fst_host = 1'b1;
					end
				endcase
			end
		end

		hcnt = 2'((a_v && a_f == FLD_HOST)) + 2'((b_v && b_f == FLD_HOST)) + 2'(c_v);
		hl_sum = {1'b0, hl_q} + (LEN_W + 1)'(hcnt);
		hl_fin = hl_sum[LEN_W] ? LEN_MAX : hl_sum[LEN_W-1:0];
		if (fst_host) fst = (hl_fin > cap_q) ? ST_HOST_TOO_LONG : ST_OK;
		else fst = fst_raw;

		ra = '{fld: a_f,      dat: CH_CR,   done: 1'b0, status: ST_OK};
		rb = '{fld: b_f,      dat: byte_s1, done: 1'b0, status: ST_OK};
		rc = '{fld: FLD_HOST, dat: CH_CR,   done: 1'b0, status: ST_OK};

		// pack the emissions in order; at most two are ever present
		r_lo = a_v ? ra : (b_v ? rb : rc);
		r_hi = (a_v && b_v) ? rb : rc;
		nout = 2'(a_v) + 2'(b_v) + 2'(c_v);

		if (fin) begin
			unique case (nout)
				2'd2: begin
					r_hi.done   = 1'b1;
					r_hi.status = fst;
				end
				2'd1: begin
					r_lo.done   = 1'b1;
					r_lo.status = fst;
				end
				default: begin
					r_lo = '{fld: FLD_STATUS, dat: 8'h00, done: 1'b1, status: fst};
					nout = 2'd1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr.ready) begin
			valid_s1 <= hdr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr.valid && hdr.ready) begin
			byte_s1 <= hdr.in_byte;
			last_s1 <= hdr.in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_METHOD;
			mc_q    <= '0;
			bc_q    <= '0;
			hl_q    <= '0;
			cr_q    <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				phase_q <= PH_METHOD;
				mc_q    <= '0;
				bc_q    <= '0;
				hl_q    <= '0;
				cr_q    <= 1'b0;
			end else begin
				phase_q <= ph_d;
				mc_q    <= mc_d;
				bc_q    <= bc_d;
				hl_q    <= hl_fin;
				cr_q    <= cr_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Result queue
	always_ff @(posedge clk) begin
		if (adv && nout != 2'd0) fifo_q[wr_q] <= r_lo;
		if (adv && nout == 2'd2) fifo_q[wr_q + PTR_W'(1)] <= r_hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (adv) wr_q <= wr_q + PTR_W'(nout);
			if (pop) rd_q <= rd_q + PTR_W'(1);
			cnt_q <= cnt_q + (adv ? CNT_W'(nout) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

	assign fld.valid      = cnt_q != '0;
	assign fld.out_field  = fifo_q[rd_q].fld;
	assign fld.out_byte   = fifo_q[rd_q].dat;
	assign fld.out_done   = fifo_q[rd_q].done;
	assign fld.out_status = fifo_q[rd_q].status;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue over capacity");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> phase_q == PH_METHOD && bc_q == '0 && hl_q == '0)
		else $error("parse state not cleared after last byte");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 && phase_q != PH_DRAIN |-> fin && nout != 2'd0)
		else $error("request ended without a final result");

	a_drain_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		adv && phase_q == PH_DRAIN |-> nout == 2'd0)
		else $error("result emitted after request finished");

endmodule
